@@ rtl/socks5_pkg.sv @@
// Shared types and result codes for the SOCKS5 handshake parser.
`default_nettype none

package socks5_pkg;

    // Result codes reported with every transaction.
    typedef enum logic [3:0] {
        RES_MORE     = 4'd0,
        RES_BAD_VER  = 4'd1,
        RES_AUTH_SEL = 4'd2,
        RES_AUTH_VER = 4'd3,
        RES_BAD_CMD  = 4'd4,
        RES_BAD_ATYP = 4'd5,
        RES_EXEC     = 4'd6,
        RES_SEL_OK   = 4'd7,
        RES_SEL_BAD  = 4'd8
    } t_status;

    // Host authentication choices.
    localparam logic [1:0] AUTH_NONE     = 2'd0;
    localparam logic [1:0] AUTH_PASSWORD = 2'd2;

    // Capture kinds.
    localparam logic [1:0] CAP_USER = 2'd0;
    localparam logic [1:0] CAP_PASS = 2'd1;
    localparam logic [1:0] CAP_ADDR = 2'd2;

    // Protocol constants.
    localparam logic [7:0] SOCKS_VERSION = 8'd5;
    localparam logic [7:0] SUBNEG_VERSION = 8'd1;
    localparam logic [7:0] ATYP_IPV4 = 8'd1;
    localparam logic [7:0] ATYP_HOST = 8'd3;
    localparam logic [7:0] ATYP_IPV6 = 8'd4;
    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;
    localparam logic [7:0] METHOD_LIMIT = 8'd3;

    // Address kind codes.
    localparam logic [1:0] ADDR_IPV4 = 2'd1;
    localparam logic [1:0] ADDR_HOST = 2'd2;
    localparam logic [1:0] ADDR_IPV6 = 2'd3;

    // One input transaction.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic [1:0] auth_choice;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  offered_methods;
        logic [1:0]  request_kind;
        logic [1:0]  address_kind;
        logic [15:0] dest_port;
        logic        capture_valid;
        logic [1:0]  capture_kind;
        logic [7:0]  capture_index;
        logic [7:0]  capture_byte;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/socks5_handshake_parser_unit.sv @@
// Top level of the SOCKS5 handshake parser: input register, stage machine, result register.
// A transaction accepted into the input register passes through the stage machine into the
// result register, where it is presented as a result until it is taken.
// Throughput: one transaction per cycle while the result register is free or draining; the
// input and result registers each hold one transaction; the stage machine steps once for each.
// Reset: synchronous, active low; clears both registers' valid flags and parser state.
`default_nettype none

module socks5_handshake_parser_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  socks5_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output socks5_pkg::t_out_item o_out_data
);
    import socks5_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item fsm_res;
    logic      advance;

    // The held transaction moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    socks5_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in_item),
        .o_res   (fsm_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_item <= fsm_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

@@ rtl/socks5_fsm.sv @@
// Handshake stage machine: parser state registers and per-transaction update logic.
`default_nettype none

module socks5_fsm (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  socks5_pkg::t_in_item  i_item,
    output socks5_pkg::t_out_item o_res
);
    import socks5_pkg::*;

    typedef enum logic [16:0] {
        S_VERSION  = 17'b0_0000_0000_0000_0001,
        S_NMETHODS = 17'b0_0000_0000_0000_0010,
        S_METHODS  = 17'b0_0000_0000_0000_0100,
        S_PW_VER   = 17'b0_0000_0000_0000_1000,
        S_USERLEN  = 17'b0_0000_0000_0001_0000,
        S_USER     = 17'b0_0000_0000_0010_0000,
        S_PASSLEN  = 17'b0_0000_0000_0100_0000,
        S_PASS     = 17'b0_0000_0000_1000_0000,
        S_REQ_VER  = 17'b0_0000_0001_0000_0000,
        S_CMD      = 17'b0_0000_0010_0000_0000,
        S_RSV      = 17'b0_0000_0100_0000_0000,
        S_ATYP     = 17'b0_0000_1000_0000_0000,
        S_HOSTLEN  = 17'b0_0001_0000_0000_0000,
        S_ADDR     = 17'b0_0010_0000_0000_0000,
        S_PORT0    = 17'b0_0100_0000_0000_0000,
        S_PORT1    = 17'b0_1000_0000_0000_0000,
        S_DONE     = 17'b1_0000_0000_0000_0000
    } t_stage;

    t_stage      r_stage, n_stage;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_len, n_len;
    logic [2:0]  r_mask, n_mask;
    logic [1:0]  r_req, n_req;
    logic [1:0]  r_addr, n_addr;
    logic [7:0]  r_port_hi, n_port_hi;
    logic [15:0] r_port, n_port;

    t_status    status;
    logic       cap_valid;
    logic [1:0] cap_kind;
    logic [7:0] cap_index;
    logic [7:0] cap_byte;
    logic [7:0] data;

    assign data = i_item.data_byte;

    // Next-state logic for one transaction.
    always_comb begin
        n_stage   = r_stage;
        n_count   = r_count;
        n_len     = r_len;
        n_mask    = r_mask;
        n_req     = r_req;
        n_addr    = r_addr;
        n_port_hi = r_port_hi;
        n_port    = r_port;
        status    = RES_MORE;
        cap_valid = 1'b0;
        cap_kind  = CAP_USER;
        cap_index = 8'd0;
        cap_byte  = 8'd0;

        if (i_item.command) begin
            // Host selects the authentication method from any stage.
            if (i_item.auth_choice == AUTH_NONE) begin
                n_stage = S_REQ_VER;
                status  = RES_SEL_OK;
            end else if (i_item.auth_choice == AUTH_PASSWORD) begin
                n_stage = S_PW_VER;
                status  = RES_SEL_OK;
            end else begin
                status = RES_SEL_BAD;
            end
        end else begin
            case (r_stage)
                S_VERSION: begin
                    if (data != SOCKS_VERSION) status = RES_BAD_VER;
                    else n_stage = S_NMETHODS;
                end
                S_NMETHODS, S_USERLEN, S_PASSLEN: begin
                    n_count = 8'd0;
                    n_len   = data;
                    case (r_stage)
                        S_NMETHODS: n_stage = S_METHODS;
                        S_USERLEN:  n_stage = S_USER;
                        default:    n_stage = S_PASS;
                    endcase
                end
                S_METHODS: begin
                    // Unknown method codes are counted but not recorded.
                    if (r_count < r_len) begin
                        if (data < METHOD_LIMIT) n_mask[data[1:0]] = 1'b1;
                        n_count = r_count + 8'd1;
                    end
                    if (n_count == r_len) status = RES_AUTH_SEL;
                end
                S_PW_VER: begin
                    if (data != SUBNEG_VERSION) status = RES_BAD_VER;
                    else n_stage = S_USERLEN;
                end
                S_USER, S_PASS, S_ADDR: begin
                    // Stream string bytes out with their position.
                    if (r_count < r_len) begin
                        cap_valid = 1'b1;
                        case (r_stage)
                            S_USER:  cap_kind = CAP_USER;
                            S_PASS:  cap_kind = CAP_PASS;
                            default: cap_kind = CAP_ADDR;
                        endcase
                        cap_index = r_count;
                        cap_byte  = data;
                        n_count   = r_count + 8'd1;
                    end
                    if (n_count == r_len) begin
                        case (r_stage)
                            S_USER: n_stage = S_PASSLEN;
                            S_PASS: begin
                                n_stage = S_REQ_VER;
                                status  = RES_AUTH_VER;
                            end
                            default: n_stage = S_PORT0;
                        endcase
                    end
                end
                S_REQ_VER: begin
                    if (data != SOCKS_VERSION) status = RES_BAD_VER;
                    else n_stage = S_CMD;
                end
                S_CMD: begin
                    if (data inside {[8'd1:8'd3]}) begin
                        n_req   = data[1:0];
                        n_stage = S_RSV;
                    end else begin
                        status = RES_BAD_CMD;
                    end
                end
                S_RSV: n_stage = S_ATYP;
                S_ATYP: begin
                    n_count = 8'd0;
                    case (data)
                        ATYP_IPV4: begin
                            n_stage = S_ADDR;
                            n_addr  = ADDR_IPV4;
                            n_len   = IPV4_LEN;
                        end
                        ATYP_HOST: begin
                            n_stage = S_HOSTLEN;
                            n_addr  = ADDR_HOST;
                            n_len   = 8'd0;
                        end
                        ATYP_IPV6: begin
                            n_stage = S_ADDR;
                            n_addr  = ADDR_IPV6;
                            n_len   = IPV6_LEN;
                        end
                        default: status = RES_BAD_ATYP;
                    endcase
                end
                S_HOSTLEN: begin
                    n_len   = data;
                    n_stage = S_ADDR;
                end
                S_PORT0: begin
                    n_port_hi = data;
                    n_stage   = S_PORT1;
                end
                S_PORT1: begin
                    n_port  = {r_port_hi, data};
                    n_stage = S_DONE;
                    status  = RES_EXEC;
                end
                default: ;
            endcase
        end
    end

    // Result reflects the state after this transaction.
    always_comb begin
        o_res.status          = status;
        o_res.offered_methods = n_mask;
        o_res.request_kind    = n_req;
        o_res.address_kind    = n_addr;
        o_res.dest_port       = n_port;
        o_res.capture_valid   = cap_valid;
        o_res.capture_kind    = cap_kind;
        o_res.capture_index   = cap_index;
        o_res.capture_byte    = cap_byte;
    end

    // State registers advance once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= S_VERSION;
            r_count   <= 8'd0;
            r_len     <= 8'd0;
            r_mask    <= 3'd0;
            r_req     <= 2'd0;
            r_addr    <= 2'd0;
            r_port_hi <= 8'd0;
            r_port    <= 16'd0;
        end else if (i_en) begin
            r_stage   <= n_stage;
            r_count   <= n_count;
            r_len     <= n_len;
            r_mask    <= n_mask;
            r_req     <= n_req;
            r_addr    <= n_addr;
            r_port_hi <= n_port_hi;
            r_port    <= n_port;
        end
    end

    // The field counter never passes the field length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_len)
        else $error("byte count exceeds field length");

    // A select of no authentication lands in the request version stage.
    a_select_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.command && (i_item.auth_choice == AUTH_NONE)
        |=> r_stage == S_REQ_VER)
        else $error("select none did not reach request stage");

    // Execute is reported only when the stage machine finishes.
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (status == RES_EXEC) |=> r_stage == S_DONE)
        else $error("execute without reaching done");

    // A capture never reports a status other than need more or auth verify.
    a_capture_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cap_valid |-> (status == RES_MORE) || (status == RES_AUTH_VER))
        else $error("capture with unexpected status");

endmodule

`default_nettype wire
